// ===== hw/rtl/clog_pkg.sv =====
// shared types and codes for the consensus log index table
// no dependencies; used by clog_ctrl, clog_dpath and the top level
package clog_pkg;

   localparam logic [2:0] CMD_APPEND       = 3'd0;
   localparam logic [2:0] CMD_READ         = 3'd1;
   localparam logic [2:0] CMD_TRUNC_AFTER  = 3'd2;
   localparam logic [2:0] CMD_TRUNC_BEFORE = 3'd3;
   localparam logic [2:0] CMD_FIND_FIRST   = 3'd4;
   localparam logic [2:0] CMD_FIND_LAST    = 3'd5;
   localparam logic [2:0] CMD_CLEAR        = 3'd6;
   localparam logic [2:0] CMD_STATUS       = 3'd7;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_MISS = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   typedef struct packed {
      logic [2:0]  command;
      logic [63:0] entry_term;
      logic [1:0]  entry_kind;
      logic [63:0] target_index;
      logic [6:0]  max_count;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [63:0] found_index;
      logic [63:0] found_term;
      logic [1:0]  found_kind;
      logic        last_of_run;
      logic [63:0] log_last_index;
      logic [63:0] log_last_term;
      logic [63:0] log_first_index;
   } rsp_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LATCH,
      OP_EXEC,
      OP_RD_LAST,
      OP_CAP_LAST,
      OP_WALK_RD,
      OP_WALK_EMIT,
      OP_WALK_CMP,
      OP_RSP_FIXED
   } dp_op_type;

   typedef struct packed {
      logic [2:0] cmd;
      logic       walk_empty;
      logic       walk_last;
      logic       hit;
      logic       rsp_pending;
   } dp_stat_type;

endpackage

// ===== hw/rtl/consensus_log_index_table.sv =====
// consensus log index table: ring of entry terms and kinds behind a base index
// one item at a time; append, truncate, clear, status: latch, execute, read last term, respond
// read range: after the last-term read, one memory read and one result per entry (one read port)
// term search: after the last-term read, entries are read and compared in turn on the single read port
// synchronous reset empties the log (base 0); entry memory is not cleared
module consensus_log_index_table import clog_pkg::*; #(
   parameter int LOG_DEPTH    = 256,
   parameter int MAX_READ_RUN = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);
   dp_op_type   op;
   dp_stat_type stat;

   clog_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .op        (op)
   );

   clog_dpath #(
      .LOG_DEPTH    (LOG_DEPTH),
      .MAX_READ_RUN (MAX_READ_RUN)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .op        (op),
      .stat      (stat),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   // never overwrite a result that has not been taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (op == OP_RSP_FIXED || op == OP_WALK_EMIT) |-> !stat.rsp_pending)
      else $error("result loaded while previous one pending");

   // a captured item is always executed next
   a_latch_exec: assert property (@(posedge clock) disable iff (reset)
      (op == OP_LATCH) |=> (op == OP_EXEC))
      else $error("latched item not executed");

   // a refused append reports no index
   a_full_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == ST_FULL) |-> (rsp_data.found_index == 64'd0))
      else $error("full append reported an index");
`endif

endmodule

// ===== hw/rtl/clog_dpath.sv =====
// datapath: entry ring memory, log pointers, walk counters and result register
// depends on clog_pkg; driven by clog_ctrl
module clog_dpath import clog_pkg::*; #(
   parameter int LOG_DEPTH    = 256,
   parameter int MAX_READ_RUN = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  req_type     req_data,
   input  dp_op_type   op,
   output dp_stat_type stat,
   input  logic        rsp_stall,
   output logic        rsp_valid,
   output rsp_type     rsp_data
);
   localparam int SW = $clog2(LOG_DEPTH);
   localparam int CW = $clog2(LOG_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(LOG_DEPTH);
   localparam logic [6:0]    RUN_C   = 7'(MAX_READ_RUN);

   logic [63:0] term_mem [LOG_DEPTH];
   logic [1:0]  kind_mem [LOG_DEPTH];

   req_type     req_ff, req_in;
   logic [SW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;
   logic [63:0] base_ff, base_in;
   logic [CW-1:0] walk_ff, walk_in;
   logic [CW-1:0] left_ff, left_in;
   logic        dir_down_ff, dir_down_in;
   logic [63:0] last_term_ff, last_term_in;
   logic [1:0]  res_status_ff, res_status_in;
   logic [63:0] res_index_ff, res_index_in;
   logic [63:0] rd_term_ff;
   logic [1:0]  rd_kind_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   logic          mem_we;
   logic [SW-1:0] wr_slot, rd_slot;
   logic          rd_en;
   logic [63:0]   last_w, walk_index_w, first_w;
   logic [6:0]    maxc_w;
   logic [63:0]   avail_w, off_w, k_w;
   logic [CW-1:0] n_w;
   logic          hit_w;

   // ring slot of an offset from the head
   function automatic logic [SW-1:0] wrap(input logic [SW-1:0] h, input logic [CW-1:0] o);
      logic [CW:0] s;
      s = {{(CW - SW + 1){1'b0}}, h} + {1'b0, o};
      if (s >= (CW + 1)'(LOG_DEPTH)) s = s - (CW + 1)'(LOG_DEPTH);
      return s[SW-1:0];
   endfunction

   assign last_w       = base_ff + {{(64 - CW){1'b0}}, count_ff};
   assign first_w      = (count_ff != '0) ? base_ff + 64'd1 : 64'd0;
   assign walk_index_w = base_ff + 64'd1 + {{(64 - CW){1'b0}}, walk_ff};
   assign maxc_w       = (req_ff.max_count > RUN_C) ? RUN_C : req_ff.max_count;
   assign avail_w      = last_w - req_ff.target_index + 64'd1;
   assign n_w          = (avail_w < {57'd0, maxc_w}) ? avail_w[CW-1:0] : CW'(maxc_w);
   assign off_w        = req_ff.target_index - base_ff - 64'd1;
   assign k_w          = req_ff.target_index - base_ff;
   assign hit_w        = (rd_term_ff == req_ff.entry_term);
   assign wr_slot      = wrap(head_ff, count_ff);
   assign rd_slot      = wrap(head_ff, (op == OP_RD_LAST) ? count_ff - CW'(1) : walk_ff);
   assign rd_en        = (op == OP_RD_LAST) || (op == OP_WALK_RD);

   always_comb begin
      req_in        = req_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      base_in       = base_ff;
      walk_in       = walk_ff;
      left_in       = left_ff;
      dir_down_in   = dir_down_ff;
      last_term_in  = last_term_ff;
      res_status_in = res_status_ff;
      res_index_in  = res_index_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      mem_we        = 1'b0;

      case (op)
         OP_LATCH: begin
            req_in = req_data;
         end
         OP_EXEC: begin
            res_status_in = ST_OK;
            res_index_in  = 64'd0;
            left_in       = '0;
            walk_in       = '0;
            dir_down_in   = 1'b0;
            case (req_ff.command)
               CMD_APPEND: begin
                  if (count_ff == DEPTH_C || last_w == '1) begin
                     res_status_in = ST_FULL;
                  end else begin
                     mem_we       = 1'b1;
                     count_in     = count_ff + CW'(1);
                     res_index_in = last_w + 64'd1;
                  end
               end
               CMD_READ: begin
                  if (maxc_w == 7'd0 || count_ff == '0 || req_ff.target_index <= base_ff
                      || req_ff.target_index > last_w) begin
                     res_status_in = ST_MISS;
                  end else begin
                     walk_in = off_w[CW-1:0];
                     left_in = n_w;
                  end
               end
               CMD_TRUNC_AFTER: begin
                  if (count_ff != '0) begin
                     if (req_ff.target_index <= base_ff) count_in = '0;
                     else if (req_ff.target_index < last_w) count_in = k_w[CW-1:0];
                  end
               end
               CMD_TRUNC_BEFORE: begin
                  if (count_ff == '0) begin
                     base_in = req_ff.target_index;
                  end else if (req_ff.target_index >= last_w) begin
                     count_in = '0;
                     base_in  = req_ff.target_index;
                  end else if (req_ff.target_index > base_ff) begin
                     head_in  = wrap(head_ff, k_w[CW-1:0]);
                     count_in = count_ff - k_w[CW-1:0];
                     base_in  = req_ff.target_index;
                  end
               end
               CMD_FIND_FIRST: begin
                  res_status_in = ST_MISS;
                  left_in       = count_ff;
               end
               CMD_FIND_LAST: begin
                  res_status_in = ST_MISS;
                  left_in       = count_ff;
                  walk_in       = count_ff - CW'(1);
                  dir_down_in   = 1'b1;
               end
               CMD_CLEAR: begin
                  count_in = '0;
               end
               default: begin
               end
            endcase
         end
         OP_CAP_LAST: begin
            last_term_in = (count_ff != '0) ? rd_term_ff : 64'd0;
         end
         OP_WALK_EMIT: begin
            rsp_valid_in           = 1'b1;
            rsp_in.status          = ST_OK;
            rsp_in.found_index     = walk_index_w;
            rsp_in.found_term      = rd_term_ff;
            rsp_in.found_kind      = rd_kind_ff;
            rsp_in.last_of_run     = (left_ff == CW'(1));
            rsp_in.log_last_index  = last_w;
            rsp_in.log_last_term   = last_term_ff;
            rsp_in.log_first_index = first_w;
            left_in                = left_ff - CW'(1);
            walk_in                = walk_ff + CW'(1);
         end
         OP_WALK_CMP: begin
            if (hit_w) begin
               res_status_in = ST_OK;
               res_index_in  = walk_index_w;
            end else begin
               left_in = left_ff - CW'(1);
               walk_in = dir_down_ff ? walk_ff - CW'(1) : walk_ff + CW'(1);
            end
         end
         OP_RSP_FIXED: begin
            rsp_valid_in           = 1'b1;
            rsp_in.status          = res_status_ff;
            rsp_in.found_index     = res_index_ff;
            rsp_in.found_term      = 64'd0;
            rsp_in.found_kind      = 2'd0;
            rsp_in.last_of_run     = 1'b1;
            rsp_in.log_last_index  = last_w;
            rsp_in.log_last_term   = last_term_ff;
            rsp_in.log_first_index = first_w;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         term_mem[wr_slot] <= req_ff.entry_term;
         kind_mem[wr_slot] <= req_ff.entry_kind;
      end
      if (rd_en) begin
         rd_term_ff <= term_mem[rd_slot];
         rd_kind_ff <= kind_mem[rd_slot];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         base_ff      <= '0;
         left_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         count_ff     <= count_in;
         base_ff      <= base_in;
         left_ff      <= left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff        <= req_in;
      walk_ff       <= walk_in;
      dir_down_ff   <= dir_down_in;
      last_term_ff  <= last_term_in;
      res_status_ff <= res_status_in;
      res_index_ff  <= res_index_in;
      rsp_ff        <= rsp_in;
   end

   assign stat.cmd         = req_ff.command;
   assign stat.walk_empty  = (left_ff == '0);
   assign stat.walk_last   = (left_ff == CW'(1));
   assign stat.hit         = hit_w;
   assign stat.rsp_pending = rsp_valid_ff;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== hw/rtl/clog_ctrl.sv =====
// controller state machine: sequences command execution and entry walks
// depends on clog_pkg; issues ops to clog_dpath
module clog_ctrl import clog_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  dp_stat_type stat,
   output dp_op_type   op
);
   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_LAST_RD,
      S_LAST_CAP,
      S_FIXED,
      S_WALK_RD,
      S_WALK_USE
   } state_type;

   state_type state_ff, state_in;
   logic      walk_cmd;

   assign walk_cmd = (stat.cmd == CMD_READ) || (stat.cmd == CMD_FIND_FIRST)
                     || (stat.cmd == CMD_FIND_LAST);
   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      op       = OP_NONE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op       = OP_LATCH;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            op       = OP_EXEC;
            state_in = S_LAST_RD;
         end
         S_LAST_RD: begin
            op       = OP_RD_LAST;
            state_in = S_LAST_CAP;
         end
         S_LAST_CAP: begin
            op       = OP_CAP_LAST;
            state_in = (walk_cmd && !stat.walk_empty) ? S_WALK_RD : S_FIXED;
         end
         S_FIXED: begin
            if (!stat.rsp_pending) begin
               op       = OP_RSP_FIXED;
               state_in = S_IDLE;
            end
         end
         S_WALK_RD: begin
            op       = OP_WALK_RD;
            state_in = S_WALK_USE;
         end
         S_WALK_USE: begin
            if (stat.cmd == CMD_READ) begin
               if (!stat.rsp_pending) begin
                  op       = OP_WALK_EMIT;
                  state_in = stat.walk_last ? S_IDLE : S_WALK_RD;
               end
            end else begin
               op = OP_WALK_CMP;
               if (stat.hit || stat.walk_last) state_in = S_FIXED;
               else state_in = S_WALK_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== tb/sv/tb.sv =====
// testbench for consensus_log_index_table: drives log commands, predicts results
// depends on clog_pkg and the consensus_log_index_table rtl
module tb;
   import clog_pkg::*;

   localparam int DEPTH = 256;
   localparam int RUN_MAX = 64;
   localparam longint unsigned CYCLE_LIMIT = 2000000;

   class log_scoreboard;
      rsp_type pending_rsp[$];
      int errors;
      logic [63:0] terms[DEPTH];
      logic [1:0] kinds[DEPTH];
      int unsigned head;
      int unsigned count;
      logic [63:0] base;

      function void clear_state();
         head = 0;
         count = 0;
         base = 0;
         errors = 0;
      endfunction

      function int unsigned slot(int unsigned off);
         return (head + off) % DEPTH;
      endfunction

      function void push(logic [1:0] st, logic [63:0] idx, logic [63:0] tm,
                         logic [1:0] kd, logic lst);
         rsp_type r;
         r.status = st;
         r.found_index = idx;
         r.found_term = tm;
         r.found_kind = kd;
         r.last_of_run = lst;
         r.log_last_index = base + count;
         r.log_last_term = count != 0 ? terms[slot(count - 1)] : 64'd0;
         r.log_first_index = count != 0 ? base + 64'd1 : 64'd0;
         pending_rsp.push_back(r);
      endfunction

      function void note_command(req_type q);
         logic [63:0] last;
         int unsigned n, off, mc, k, i;
         logic [63:0] avail;
         last = base + count;
         case (q.command)
            CMD_APPEND: begin
               if (count >= DEPTH || last == '1) begin
                  push(ST_FULL, 0, 0, 0, 1);
               end else begin
                  terms[slot(count)] = q.entry_term;
                  kinds[slot(count)] = q.entry_kind;
                  count++;
                  push(ST_OK, last + 1, 0, 0, 1);
               end
            end
            CMD_READ: begin
               mc = q.max_count > RUN_MAX ? RUN_MAX : q.max_count;
               if (mc == 0 || count == 0 || q.target_index <= base ||
                   q.target_index > last) begin
                  push(ST_MISS, 0, 0, 0, 1);
               end else begin
                  avail = last - q.target_index + 1;
                  n = avail < 64'(mc) ? 32'(avail) : mc;
                  off = 32'(q.target_index - base - 1);
                  for (i = 0; i < n; i++)
                     push(ST_OK, q.target_index + i, terms[slot(off + i)],
                          kinds[slot(off + i)], i + 1 == n);
               end
            end
            CMD_TRUNC_AFTER: begin
               if (count != 0) begin
                  if (q.target_index <= base) count = 0;
                  else if (q.target_index < last) count = 32'(q.target_index - base);
               end
               push(ST_OK, 0, 0, 0, 1);
            end
            CMD_TRUNC_BEFORE: begin
               if (count == 0) begin
                  base = q.target_index;
               end else if (q.target_index >= last) begin
                  count = 0;
                  base = q.target_index;
               end else if (q.target_index > base) begin
                  k = 32'(q.target_index - base);
                  head = slot(k);
                  count -= k;
                  base = q.target_index;
               end
               push(ST_OK, 0, 0, 0, 1);
            end
            CMD_FIND_FIRST: begin
               n = 0;
               for (i = 0; i < count && n == 0; i++)
                  if (terms[slot(i)] == q.entry_term) n = i + 1;
               if (n != 0) push(ST_OK, base + n, 0, 0, 1);
               else push(ST_MISS, 0, 0, 0, 1);
            end
            CMD_FIND_LAST: begin
               n = 0;
               for (i = count; i > 0 && n == 0; i--)
                  if (terms[slot(i - 1)] == q.entry_term) n = i;
               if (n != 0) push(ST_OK, base + n, 0, 0, 1);
               else push(ST_MISS, 0, 0, 0, 1);
            end
            CMD_CLEAR: begin
               count = 0;
               push(ST_OK, 0, 0, 0, 1);
            end
            default: push(ST_OK, 0, 0, 0, 1);
         endcase
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (pending_rsp.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result %h", got);
            return;
         end
         want = pending_rsp.pop_front();
         if (got !== want) begin
            errors++;
            if (errors <= 10)
               $display("mismatch: expected %h actual %h", want, got);
         end
      endfunction
   endclass

   logic clock, reset;
   logic req_valid, req_stall, rsp_valid, rsp_stall;
   req_type req_data;
   rsp_type rsp_data;
   log_scoreboard board;
   int send_idle_pct, recv_stall_pct;
   longint unsigned cycles = 0;
   logic [63:0] recent_term;

   consensus_log_index_table uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   initial begin
      board = new();
      board.clear_state();
      send_idle_pct = 0;
      recv_stall_pct = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // receiver: sample accepted results, then pick the next stall
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_result(rsp_data);
      rsp_stall <= reset ? 1'b0 : ($urandom_range(99) < recv_stall_pct);
   end

   // valid stays high through the stall; it drops afterwards unless the next item follows at once
   task automatic send(req_type q);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_data <= q;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_command(q);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (board.pending_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic req_type make_cmd(logic [2:0] c, logic [63:0] tm, logic [1:0] kd,
                                        logic [63:0] ti, logic [6:0] mc);
      req_type q;
      q.command = c;
      q.entry_term = tm;
      q.entry_kind = kd;
      q.target_index = ti;
      q.max_count = mc;
      return q;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // mostly well-formed commands aimed near the live index range
   function automatic req_type random_cmd();
      req_type q;
      logic [63:0] lo, hi;
      int sel;
      q = make_cmd($urandom_range(7), rand64(), $urandom_range(3), rand64(),
                   $urandom_range(127));
      lo = board.base;
      hi = board.base + board.count;
      sel = $urandom_range(99);
      if (sel < 40) q.command = CMD_APPEND;
      else if (sel < 50) q.command = $urandom_range(1) ? CMD_FIND_FIRST : CMD_FIND_LAST;
      if ($urandom_range(3) != 0) q.entry_term = recent_term + $urandom_range(3);
      if ($urandom_range(9) != 0) q.target_index = lo + $urandom_range(board.count + 1);
      if (q.command == CMD_TRUNC_AFTER && $urandom_range(3) != 0)
         q.target_index = hi - $urandom_range(3);
      if ((q.command == CMD_CLEAR || q.command == CMD_TRUNC_BEFORE) && $urandom_range(2) != 0)
         q.command = CMD_APPEND;
      if (q.command == CMD_READ && $urandom_range(3) != 0) q.max_count = $urandom_range(8);
      if (q.command == CMD_APPEND && $urandom_range(7) == 0) recent_term++;
      return q;
   endfunction

   initial begin
      int i, ph;
      reset = 1'b1;
      req_valid = 1'b0;
      rsp_stall = 1'b0;
      req_data = '0;
      recent_term = 5;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty log cases, extremes of the index range, appends refused as full
      send(make_cmd(CMD_STATUS, '1, 3, '1, 127));
      send(make_cmd(CMD_READ, 0, 0, 1, 1));
      send(make_cmd(CMD_TRUNC_AFTER, 0, 0, 5, 1));
      send(make_cmd(CMD_FIND_FIRST, 0, 0, 0, 1));
      send(make_cmd(CMD_TRUNC_BEFORE, 0, 0, 64'hFFFF_FFFF_FFFF_FFFE, 1));
      send(make_cmd(CMD_APPEND, '1, 3, 0, 0));
      send(make_cmd(CMD_APPEND, 0, 2, 0, 0));
      send(make_cmd(CMD_READ, 0, 0, '1, 127));
      send(make_cmd(CMD_READ, 0, 0, '1, 0));
      send(make_cmd(CMD_TRUNC_BEFORE, 0, 0, 100, 1));
      for (i = 0; i < 258; i++)
         send(make_cmd(CMD_APPEND, 64'(i / 3), 2'(i), 64'd0, 7'd1));
      send(make_cmd(CMD_READ, 0, 0, 101, 127));
      send(make_cmd(CMD_FIND_FIRST, 7, 0, 0, 1));
      send(make_cmd(CMD_FIND_LAST, 7, 0, 0, 1));
      send(make_cmd(CMD_FIND_LAST, 64'hdead, 0, 0, 1));
      send(make_cmd(CMD_TRUNC_BEFORE, 0, 0, 290, 1));
      send(make_cmd(CMD_TRUNC_AFTER, 0, 0, 340, 1));
      send(make_cmd(CMD_TRUNC_AFTER, 0, 0, 100, 1));
      send(make_cmd(CMD_CLEAR, 0, 0, 0, 1));
      wait_drained();

      for (ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
            default: begin send_idle_pct = 29; recv_stall_pct = 29; end
         endcase
         for (i = 0; i < 46; i++) begin
            send(random_cmd());
            if (i == 23) wait_drained();
         end
      end

      send_idle_pct = 0;
      recv_stall_pct = 0;
      wait_drained();
      repeat (200) @(posedge clock);
      if (board.errors == 0 && board.pending_rsp.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule

// ===== files.f =====
hw/rtl/clog_pkg.sv
hw/rtl/clog_dpath.sv
hw/rtl/clog_ctrl.sv
hw/rtl/consensus_log_index_table.sv
tb/sv/tb.sv
